FILE: rtl/core/pts_pkg.sv
// Package: shared types, codes and sizing constants of the periodic task scheduler.
package pts_pkg;

    localparam int TASK_SLOTS  = 8;
    localparam int MAX_RESULTS = 8;
    localparam int IDX_W       = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CNT_W       = $clog2(TASK_SLOTS + 1);
    localparam int FND_W       = $clog2(MAX_RESULTS + 1);

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_ADD   = 2'd1,
        MODE_RUN   = 2'd2,
        MODE_CLEAR = 2'd3
    } t_mode;

    localparam logic [1:0] ST_ACK  = 2'd0;
    localparam logic [1:0] ST_DUE  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_TICK,
        CMD_ADD,
        CMD_CLEAR,
        CMD_RUN,
        CMD_STEP,
        CMD_FINISH
    } t_cmd;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    typedef struct packed {
        logic scan_end;
    } t_dp_status;

    function automatic logic [2:0] to_task_index(input logic [IDX_W-1:0] idx);
        logic [IDX_W+2:0] w;
        w = {3'b000, idx};
        return w[2:0];
    endfunction

endpackage

FILE: rtl/core/pts_ctrl.sv
// Controller: request decode and run-pass sequencing of the periodic task scheduler.
module pts_ctrl import pts_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic [1:0] i_mode,
    input  t_dp_status i_status,
    output t_cmd       o_cmd,
    output logic       busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NONE;
        busy    = (r_state == S_SCAN);
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (t_mode'(i_mode))
                        MODE_TICK:  o_cmd = CMD_TICK;
                        MODE_ADD:   o_cmd = CMD_ADD;
                        MODE_RUN: begin
                            o_cmd   = CMD_RUN;
                            n_state = S_SCAN;
                        end
                        MODE_CLEAR: o_cmd = CMD_CLEAR;
                        default:    o_cmd = CMD_NONE;
                    endcase
                end
            end
            S_SCAN: begin
                if (i_status.scan_end) begin
                    o_cmd   = CMD_FINISH;
                    n_state = S_IDLE;
                end else begin
                    o_cmd = CMD_STEP;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

FILE: rtl/core/pts_datapath.sv
// Datapath: tick counter, task table, scan counters and result register.
module pts_datapath import pts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [31:0] i_period,
    input  logic        i_has_handler,
    output t_dp_status  o_status,
    output logic        o_strobe,
    output logic [1:0]  o_status_code,
    output logic [2:0]  o_task_index,
    output logic [31:0] o_tick_now,
    output logic        o_last
);

    logic [31:0]      r_tick;
    logic [CNT_W-1:0] r_count;
    logic [31:0]      r_period [TASK_SLOTS];
    logic [31:0]      r_last_run [TASK_SLOTS];
    logic             r_en [TASK_SLOTS];
    logic             r_hh [TASK_SLOTS];
    logic [CNT_W-1:0] r_idx;
    logic [FND_W-1:0] r_found;
    logic             r_pend_valid;
    logic [IDX_W-1:0] r_pend_idx;

    logic             r_strobe;
    logic [1:0]       r_status;
    logic [2:0]       r_tidx;
    logic [31:0]      r_otick;
    logic             r_olast;

    logic             n_strobe;
    logic [1:0]       n_status;
    logic [2:0]       n_tidx;
    logic [31:0]      n_otick;
    logic             n_olast;

    logic [IDX_W-1:0] scan_slot;
    logic [IDX_W-1:0] add_slot;
    logic [31:0]      elapsed;
    logic             full;
    logic             scan_end;
    logic             entry_due;

    assign scan_slot = r_idx[IDX_W-1:0];
    assign add_slot  = r_count[IDX_W-1:0];
    assign elapsed   = r_tick - r_last_run[scan_slot];
    assign full      = (r_count >= CNT_W'(TASK_SLOTS));
    assign scan_end  = (r_idx >= r_count) || (r_found == FND_W'(MAX_RESULTS));
    assign entry_due = r_en[scan_slot] && r_hh[scan_slot] && (elapsed >= r_period[scan_slot]);

    assign o_status.scan_end = scan_end;

    always_comb begin
        n_strobe = 1'b0;
        n_status = ST_ACK;
        n_tidx   = 3'd0;
        n_olast  = 1'b1;
        n_otick  = r_tick;
        case (i_cmd)
            CMD_TICK: begin
                n_strobe = 1'b1;
                n_otick  = r_tick + 32'd1;
            end
            CMD_ADD: begin
                n_strobe = 1'b1;
                n_status = full ? ST_FULL : ST_ACK;
            end
            CMD_CLEAR: n_strobe = 1'b1;
            CMD_STEP: begin
                if (entry_due && r_pend_valid) begin
                    n_strobe = 1'b1;
                    n_status = ST_DUE;
                    n_tidx   = to_task_index(r_pend_idx);
                    n_olast  = 1'b0;
                end
            end
            CMD_FINISH: begin
                n_strobe = 1'b1;
                if (r_pend_valid) begin
                    n_status = ST_DUE;
                    n_tidx   = to_task_index(r_pend_idx);
                end
            end
            default: n_strobe = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick       <= '0;
            r_count      <= '0;
            r_idx        <= '0;
            r_found      <= '0;
            r_pend_valid <= 1'b0;
            r_strobe     <= 1'b0;
            for (int k = 0; k < TASK_SLOTS; k++) begin
                r_en[k] <= 1'b0;
            end
        end else begin
            r_strobe <= n_strobe;
            case (i_cmd)
                CMD_TICK: r_tick <= r_tick + 32'd1;
                CMD_ADD: begin
                    if (!full) begin
                        r_en[add_slot] <= 1'b1;
                        r_count        <= r_count + CNT_W'(1);
                    end
                end
                CMD_CLEAR: begin
                    r_count <= '0;
                    for (int k = 0; k < TASK_SLOTS; k++) begin
                        r_en[k] <= 1'b0;
                    end
                end
                CMD_RUN: begin
                    r_idx        <= '0;
                    r_found      <= '0;
                    r_pend_valid <= 1'b0;
                end
                CMD_STEP: begin
                    r_idx <= r_idx + CNT_W'(1);
                    if (entry_due) begin
                        r_found      <= r_found + FND_W'(1);
                        r_pend_valid <= 1'b1;
                    end
                end
                CMD_FINISH: r_pend_valid <= 1'b0;
                default: r_pend_valid <= r_pend_valid;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_tidx   <= n_tidx;
        r_otick  <= n_otick;
        r_olast  <= n_olast;
        if (i_cmd == CMD_ADD && !full) begin
            r_period[add_slot]   <= i_period;
            r_last_run[add_slot] <= r_tick;
            r_hh[add_slot]       <= i_has_handler;
        end
        if (i_cmd == CMD_STEP && entry_due) begin
            r_last_run[scan_slot] <= r_tick;
            r_pend_idx            <= scan_slot;
        end
    end

    assign o_strobe      = r_strobe;
    assign o_status_code = r_status;
    assign o_task_index  = r_tidx;
    assign o_tick_now    = r_otick;
    assign o_last        = r_olast;

endmodule

FILE: rtl/core/periodic_task_scheduler.sv
// Top level: periodic task scheduler with tick counter and eight-entry task table.
//
//  channel   handshake               payload
//  request   start & !busy           i_mode, i_period, i_has_handler
//  result    o_strobe (one cycle)    o_status, o_task_index, o_tick_now, o_last
//
//  Tick, add and clear results strobe in the cycle after the request.
//  During a run pass busy holds while the scan steps through the entries (ending
//  early at MAX_RESULTS due tasks) and a finish step; each due task is reported the
//  cycle after the next due one is found, the final result the cycle after scan end.
//  busy is high during the scan. Reset is synchronous and clears the tick and table.
//  The receiver cannot stall; every strobe is taken.
module periodic_task_scheduler import pts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_mode,
    input  logic [31:0] i_period,
    input  logic        i_has_handler,
    output logic        o_strobe,
    output logic [1:0]  o_status,
    output logic [2:0]  o_task_index,
    output logic [31:0] o_tick_now,
    output logic        o_last
);

    t_cmd       cmd;
    t_dp_status dp_status;

    pts_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_mode   (i_mode),
        .i_status (dp_status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    pts_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_period      (i_period),
        .i_has_handler (i_has_handler),
        .o_status      (dp_status),
        .o_strobe      (o_strobe),
        .o_status_code (o_status),
        .o_task_index  (o_task_index),
        .o_tick_now    (o_tick_now),
        .o_last        (o_last)
    );

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_mode != MODE_RUN) |=> (o_strobe && o_last))
        else $error("single-result request did not strobe a final result");

    a_scan_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && busy) |-> (o_status == ST_DUE && !o_last))
        else $error("result during scan is not a non-final due task");

    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != ST_DUE) |-> (o_task_index == 3'd0))
        else $error("task index nonzero on a non-due result");

    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_mode == MODE_RUN) |=> busy)
        else $error("run pass did not start a scan");

endmodule

FILE: tb/sv/periodic_task_scheduler_test.sv
// Testbench: directed table plus random requests, checked against a scheduler predictor.
module periodic_task_scheduler_test
    import pts_pkg::*;
();

    localparam int          RANDOM_REQUESTS = 250;
    localparam int          CALM_TAIL       = 40;
    localparam int unsigned CYCLE_LIMIT     = 200000;
    localparam int          DIRECTED_ROWS   = 24;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  task_index;
        logic [31:0] tick_now;
        logic        last_flag;
    } t_sched_report;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] period;
        logic        has_handler;
        logic        typed;
        logic [1:0]  status;
        logic [31:0] tick_now;
    } t_directed_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_mode;
    logic [31:0] i_period;
    logic        i_has_handler;
    logic        o_strobe;
    logic [1:0]  o_status;
    logic [2:0]  o_task_index;
    logic [31:0] o_tick_now;
    logic        o_last;

    logic [31:0] tick_model;
    int          tasks_held;
    logic [31:0] period_model [TASK_SLOTS];
    logic [31:0] last_run_model [TASK_SLOTS];
    logic        enabled_model [TASK_SLOTS];
    logic        handler_model [TASK_SLOTS];

    t_sched_report pending_reports [$];
    t_directed_row directed_rows [DIRECTED_ROWS];

    int unsigned cycle_count;
    int          mismatch_count;
    int          reports_checked;
    int          requests_sent;
    int          run_passes;
    int          due_reports;
    int          full_rejects;

    periodic_task_scheduler u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_mode        (i_mode),
        .i_period      (i_period),
        .i_has_handler (i_has_handler),
        .o_strobe      (o_strobe),
        .o_status      (o_status),
        .o_task_index  (o_task_index),
        .o_tick_now    (o_tick_now),
        .o_last        (o_last)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL periodic_task_scheduler");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic clear_task_table();
        tasks_held = 0;
        for (int i = 0; i < TASK_SLOTS; i++) begin
            period_model[i]   = '0;
            last_run_model[i] = '0;
            enabled_model[i]  = 1'b0;
            handler_model[i]  = 1'b0;
        end
    endtask

    task automatic push_report(input logic [1:0] status, input logic [2:0] idx,
                               input logic fin);
        t_sched_report r;
        r.status     = status;
        r.task_index = idx;
        r.tick_now   = tick_model;
        r.last_flag  = fin;
        pending_reports.push_back(r);
    endtask

    task automatic predict_schedule(input logic [1:0] mode, input logic [31:0] period,
                                    input logic hh);
        int          found;
        logic [31:0] elapsed;
        found = 0;
        case (mode)
            MODE_TICK: begin
                tick_model = tick_model + 32'd1;
                push_report(ST_ACK, 3'd0, 1'b1);
            end
            MODE_ADD: begin
                if (tasks_held < TASK_SLOTS) begin
                    period_model[tasks_held]   = period;
                    last_run_model[tasks_held] = tick_model;
                    enabled_model[tasks_held]  = 1'b1;
                    handler_model[tasks_held]  = hh;
                    tasks_held++;
                    push_report(ST_ACK, 3'd0, 1'b1);
                end else begin
                    full_rejects++;
                    push_report(ST_FULL, 3'd0, 1'b1);
                end
            end
            MODE_RUN: begin
                run_passes++;
                for (int i = 0; i < tasks_held && found < MAX_RESULTS; i++) begin
                    elapsed = tick_model - last_run_model[i];
                    if (enabled_model[i] && handler_model[i] && elapsed >= period_model[i]) begin
                        last_run_model[i] = tick_model;
                        push_report(ST_DUE, 3'(i), 1'b0);
                        found++;
                    end
                end
                if (found == 0) begin
                    push_report(ST_ACK, 3'd0, 1'b1);
                end else begin
                    due_reports += found;
                    pending_reports[pending_reports.size() - 1].last_flag = 1'b1;
                end
            end
            default: begin
                clear_task_table();
                push_report(ST_ACK, 3'd0, 1'b1);
            end
        endcase
    endtask

    task automatic send_request(input logic [1:0] mode, input logic [31:0] period,
                                input logic hh);
        @(negedge i_clk);
        start         <= 1'b1;
        i_mode        <= mode;
        i_period      <= period;
        i_has_handler <= hh;
        do @(posedge i_clk); while (busy);
        predict_schedule(mode, period, hh);
        requests_sent++;
    endtask

    task automatic hold_off(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        t_sched_report want;
        if (i_rst_n && o_strobe) begin
            if (pending_reports.size() == 0) begin
                report_mismatch($sformatf("report with nothing pending: status %0d index %0d",
                                          o_status, o_task_index));
            end else begin
                want = pending_reports.pop_front();
                reports_checked++;
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d", o_status, want.status));
                if (o_task_index !== want.task_index)
                    report_mismatch($sformatf("task_index %0d, want %0d",
                                              o_task_index, want.task_index));
                if (o_tick_now !== want.tick_now)
                    report_mismatch($sformatf("tick_now %0d, want %0d",
                                              o_tick_now, want.tick_now));
                if (o_last !== want.last_flag)
                    report_mismatch($sformatf("last %0b, want %0b", o_last, want.last_flag));
            end
        end
    end

    initial begin
        logic [1:0]    mode;
        logic [31:0]   period;
        logic          hh;
        int            pick;
        t_sched_report typed_report;

        cycle_count     = 0;
        mismatch_count  = 0;
        reports_checked = 0;
        requests_sent   = 0;
        run_passes      = 0;
        due_reports     = 0;
        full_rejects    = 0;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_mode          = MODE_TICK;
        i_period        = '0;
        i_has_handler   = 1'b0;
        tick_model      = '0;
        clear_task_table();

        directed_rows = '{
            '{MODE_RUN,   32'd0,          1'b0, 1'b1, ST_ACK,  32'd0},
            '{MODE_TICK,  32'd0,          1'b0, 1'b1, ST_ACK,  32'd1},
            '{MODE_ADD,   32'd0,          1'b1, 1'b1, ST_ACK,  32'd1},
            '{MODE_ADD,   32'hFFFF_FFFF,  1'b1, 1'b1, ST_ACK,  32'd1},
            '{MODE_ADD,   32'd2,          1'b0, 1'b1, ST_ACK,  32'd1},
            '{MODE_ADD,   32'd1,          1'b1, 1'b1, ST_ACK,  32'd1},
            '{MODE_RUN,   32'd0,          1'b0, 1'b0, ST_ACK,  32'd0},
            '{MODE_TICK,  32'hFFFF_FFFF,  1'b1, 1'b1, ST_ACK,  32'd2},
            '{MODE_RUN,   32'd0,          1'b0, 1'b0, ST_ACK,  32'd0},
            '{MODE_CLEAR, 32'd0,          1'b0, 1'b1, ST_ACK,  32'd2},
            '{MODE_ADD,   32'd0,          1'b1, 1'b1, ST_ACK,  32'd2},
            '{MODE_ADD,   32'd0,          1'b1, 1'b1, ST_ACK,  32'd2},
            '{MODE_ADD,   32'd0,          1'b1, 1'b1, ST_ACK,  32'd2},
            '{MODE_ADD,   32'd0,          1'b1, 1'b1, ST_ACK,  32'd2},
            '{MODE_ADD,   32'd0,          1'b1, 1'b1, ST_ACK,  32'd2},
            '{MODE_ADD,   32'd0,          1'b1, 1'b1, ST_ACK,  32'd2},
            '{MODE_ADD,   32'd0,          1'b1, 1'b1, ST_ACK,  32'd2},
            '{MODE_ADD,   32'd0,          1'b1, 1'b1, ST_ACK,  32'd2},
            '{MODE_ADD,   32'hFFFF_FFFF,  1'b0, 1'b1, ST_FULL, 32'd2},
            '{MODE_RUN,   32'd0,          1'b0, 1'b0, ST_ACK,  32'd0},
            '{MODE_TICK,  32'd0,          1'b0, 1'b1, ST_ACK,  32'd3},
            '{MODE_RUN,   32'd0,          1'b0, 1'b0, ST_ACK,  32'd0},
            '{MODE_CLEAR, 32'hFFFF_FFFF,  1'b1, 1'b1, ST_ACK,  32'd3},
            '{MODE_RUN,   32'd0,          1'b0, 1'b1, ST_ACK,  32'd3}
        };

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[r]) begin
            send_request(directed_rows[r].mode, directed_rows[r].period,
                         directed_rows[r].has_handler);
            if (directed_rows[r].typed) begin
                typed_report.status     = directed_rows[r].status;
                typed_report.task_index = 3'd0;
                typed_report.tick_now   = directed_rows[r].tick_now;
                typed_report.last_flag  = 1'b1;
                void'(pending_reports.pop_back());
                pending_reports.push_back(typed_report);
            end
            if ($urandom_range(0, 2) == 0) hold_off($urandom_range(1, 11));
        end

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35)      mode = MODE_TICK;
            else if (pick < 60) mode = MODE_ADD;
            else if (pick < 92) mode = MODE_RUN;
            else                mode = MODE_CLEAR;
            pick = $urandom_range(0, 9);
            if (pick < 7)       period = 32'($urandom_range(0, 15));
            else if (pick < 9)  period = $urandom;
            else                period = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'd0;
            hh = ($urandom_range(0, 4) != 0);
            send_request(mode, period, hh);
            if (n < RANDOM_REQUESTS - CALM_TAIL && $urandom_range(0, 3) == 0)
                hold_off($urandom_range(1, 11));
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (pending_reports.size() != 0)
            report_mismatch($sformatf("%0d reports never arrived", pending_reports.size()));

        $display("covered %0d requests, %0d run passes, %0d due tasks, %0d full rejects",
                 requests_sent, run_passes, due_reports, full_rejects);
        $display("checked %0d reports, %0d mismatches", reports_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("PASS periodic_task_scheduler");
        end else begin
            $display("FAIL periodic_task_scheduler");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/pts_pkg.sv
rtl/core/pts_ctrl.sv
rtl/core/pts_datapath.sv
rtl/core/periodic_task_scheduler.sv
tb/sv/periodic_task_scheduler_test.sv
